/* rtl/tfw_pkg.sv */
// ----------------------------------------------------------------------------
// tfw_pkg
// Shared types and constants for the texture window texel fetch block.
// ----------------------------------------------------------------------------
package tfw_pkg;

    // video memory geometry (power-of-two width and height)
    localparam int MEM_WIDTH  = 1024;
    localparam int MEM_HEIGHT = 512;
    localparam int COL_W      = $clog2(MEM_WIDTH);
    localparam int ROW_W      = $clog2(MEM_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DATA_W     = 16;

    // texel marking
    localparam logic [DATA_W-1:0] STP_BIT = 16'h8000;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // texture formats (codes 2 and 3 are both 15-bit direct)
    localparam logic [1:0] FMT_4BIT = 2'd0;
    localparam logic [1:0] FMT_8BIT = 2'd1;

    // register bus
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_FORMAT    = 3'd0;
    localparam logic [2:0] REG_PAGE_X    = 3'd1;
    localparam logic [2:0] REG_PAGE_Y    = 3'd2;
    localparam logic [2:0] REG_PALETTE_X = 3'd3;
    localparam logic [2:0] REG_PALETTE_Y = 3'd4;
    localparam logic [2:0] REG_WINDOW    = 3'd5;

    // configuration set seen by the datapath
    typedef struct packed {
        logic [1:0]  texture_format;
        logic [9:0]  page_x;
        logic [8:0]  page_y;
        logic [9:0]  palette_x;
        logic [8:0]  palette_y;
        logic [19:0] tex_window;
    } cfg_t;

endpackage

/* rtl/texture_window_texel_fetch.sv */
// ----------------------------------------------------------------------------
// texture_window_texel_fetch
// Video memory with texel fetch: write items store one word, fetch items
// return one windowed texel, through a palette or read directly.
// ----------------------------------------------------------------------------
//
//  channel  handshake           payload
//  -------  ------------------  ---------------------------------------------
//  in       in_valid/in_ready   op mem_x mem_y write_data u_start v_start
//                               column line mirror_x mirror_y last_in
//  out      out_valid/out_ready texel last_out
//  cfg      psel/penable/pready paddr pwrite pwdata prdata
//
//  write item: the memory is written at the accept edge
//  fetches pass S_PAGE (and S_PAL for palette formats); the single memory port
//  carries the packed word read and then the dependent palette read
//  a finished texel goes to an output register; the next item is taken
//  while it waits, and a fetch stalls only if that register is still full
//  reset clears control and the configuration registers; memory contents are kept as written
//
module texture_window_texel_fetch (
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [9:0]                     mem_x,
    input  logic [8:0]                     mem_y,
    input  logic [15:0]                    write_data,
    input  logic [7:0]                     u_start,
    input  logic [7:0]                     v_start,
    input  logic [9:0]                     column,
    input  logic [8:0]                     line,
    input  logic                           mirror_x,
    input  logic                           mirror_y,
    input  logic                           last_in,
    // result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [15:0]                    texel,
    output logic                           last_out,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tfw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tfw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tfw_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PAGE = 3'b010,
        S_PAL  = 3'b100
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    tfw_pkg::cfg_t                  cfg;
    logic                           accept;
    logic                           is_pal;
    logic                           out_free;
    logic                           finish;
    logic                           mem_we;
    logic                           mem_re;
    logic [tfw_pkg::ADDR_W-1:0]     mem_addr;
    logic [tfw_pkg::DATA_W-1:0]     mem_rdata;
    logic [tfw_pkg::ADDR_W-1:0]     wr_addr;
    logic [tfw_pkg::ADDR_W-1:0]     page_addr;
    logic [tfw_pkg::ADDR_W-1:0]     pal_addr;
    logic [1:0]                     u_lo;
    logic [1:0]                     u_lo_reg;
    logic                           last_reg;
    logic                           out_valid_reg;
    logic [tfw_pkg::DATA_W-1:0]     texel_reg;
    logic                           last_out_reg;
    logic [tfw_pkg::DATA_W-1:0]     texel_next;

    // configuration registers
    tfw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // address generation
    tfw_addr u_addr (
        .cfg         (cfg),
        .mem_x       (mem_x),
        .mem_y       (mem_y),
        .u_start     (u_start),
        .v_start     (v_start),
        .column      (column),
        .line        (line),
        .mirror_x    (mirror_x),
        .mirror_y    (mirror_y),
        .packed_word (mem_rdata),
        .u_lo_held   (u_lo_reg),
        .wr_addr     (wr_addr),
        .page_addr   (page_addr),
        .u_lo        (u_lo),
        .pal_addr    (pal_addr)
    );

    // video memory
    tfw_vram #(
        .DATA_W (tfw_pkg::DATA_W),
        .ADDR_W (tfw_pkg::ADDR_W)
    ) u_vram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (write_data),
        .rdata (mem_rdata)
    );

    // handshake and sequencing conditions
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_pal   = (cfg.texture_format == tfw_pkg::FMT_4BIT) ||
                      (cfg.texture_format == tfw_pkg::FMT_8BIT);
    assign out_free = !out_valid_reg || out_ready;
    assign finish   = (((state_reg == S_PAGE) && !is_pal) || (state_reg == S_PAL)) &&
                      out_free;

    // memory port arbitration
    assign mem_we = accept && (op == tfw_pkg::OP_WRITE);
    assign mem_re = (accept && (op == tfw_pkg::OP_FETCH)) ||
                    ((state_reg == S_PAGE) && is_pal);

    always_comb
    begin
        if (state_reg == S_PAGE)
        begin
            mem_addr = pal_addr;
        end
        else if (op == tfw_pkg::OP_WRITE)
        begin
            mem_addr = wr_addr;
        end
        else
        begin
            mem_addr = page_addr;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == tfw_pkg::OP_FETCH))
                begin
                    state_next = S_PAGE;
                end
            end
            S_PAGE:
            begin
                if (is_pal)
                begin
                    state_next = S_PAL;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // per-fetch side data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_lo_reg <= u_lo;
            last_reg <= last_in;
        end
    end

    // nonzero texels get the mask bit
    assign texel_next = (mem_rdata != '0) ? (mem_rdata | tfw_pkg::STP_BIT) : '0;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            texel_reg    <= texel_next;
            last_out_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign texel     = texel_reg;
    assign last_out  = last_out_reg;

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_fetch_to_page: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == tfw_pkg::OP_FETCH)) |=> (state_reg == S_PAGE))
        else $error("fetch item did not start a page read");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == tfw_pkg::OP_WRITE)) |=> (state_reg == S_IDLE))
        else $error("write item left the idle state");

    a_page_to_palette: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PAGE) && is_pal) |=> (state_reg == S_PAL))
        else $error("palette lookup skipped");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(texel_reg)))
        else $error("pending texel lost or overwritten");

endmodule

/* rtl/tfw_vram.sv */
// ----------------------------------------------------------------------------
// tfw_vram
// Single-port video memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module tfw_vram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 19
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tfw_regs.sv */
// ----------------------------------------------------------------------------
// tfw_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module tfw_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tfw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tfw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output tfw_pkg::cfg_t                   cfg
);

    tfw_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[tfw_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                tfw_pkg::REG_FORMAT:    cfg_reg.texture_format <= pwdata[1:0];
                tfw_pkg::REG_PAGE_X:    cfg_reg.page_x         <= pwdata[9:0];
                tfw_pkg::REG_PAGE_Y:    cfg_reg.page_y         <= pwdata[8:0];
                tfw_pkg::REG_PALETTE_X: cfg_reg.palette_x      <= pwdata[9:0];
                tfw_pkg::REG_PALETTE_Y: cfg_reg.palette_y      <= pwdata[8:0];
                tfw_pkg::REG_WINDOW:    cfg_reg.tex_window     <= pwdata[19:0];
                default:                cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            tfw_pkg::REG_FORMAT:    prdata = {30'd0, cfg_reg.texture_format};
            tfw_pkg::REG_PAGE_X:    prdata = {22'd0, cfg_reg.page_x};
            tfw_pkg::REG_PAGE_Y:    prdata = {23'd0, cfg_reg.page_y};
            tfw_pkg::REG_PALETTE_X: prdata = {22'd0, cfg_reg.palette_x};
            tfw_pkg::REG_PALETTE_Y: prdata = {23'd0, cfg_reg.palette_y};
            tfw_pkg::REG_WINDOW:    prdata = {12'd0, cfg_reg.tex_window};
            default:                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/tfw_addr.sv */
// ----------------------------------------------------------------------------
// tfw_addr
// Address generation: write address, windowed texture page address and
// palette entry address from the fetched packed word.
// ----------------------------------------------------------------------------
module tfw_addr (
    input  tfw_pkg::cfg_t                 cfg,
    input  logic [9:0]                    mem_x,
    input  logic [8:0]                    mem_y,
    input  logic [7:0]                    u_start,
    input  logic [7:0]                    v_start,
    input  logic [9:0]                    column,
    input  logic [8:0]                    line,
    input  logic                          mirror_x,
    input  logic                          mirror_y,
    input  logic [tfw_pkg::DATA_W-1:0]    packed_word,
    input  logic [1:0]                    u_lo_held,
    output logic [tfw_pkg::ADDR_W-1:0]    wr_addr,
    output logic [tfw_pkg::ADDR_W-1:0]    page_addr,
    output logic [1:0]                    u_lo,
    output logic [tfw_pkg::ADDR_W-1:0]    pal_addr
);

    localparam int AW = tfw_pkg::ADDR_W;

    logic [7:0]  u_raw;
    logic [7:0]  v_raw;
    logic [7:0]  u_win;
    logic [7:0]  v_win;
    logic [7:0]  u_word;
    logic [9:0]  page_row;
    logic [10:0] page_col;
    logic [7:0]  pal_idx;
    logic [10:0] pal_col;

    // texture window: replace masked bits with offset bits
    function automatic logic [7:0] window_coord(
        input logic [7:0] c,
        input logic [4:0] mask,
        input logic [4:0] off
    );
        logic [7:0] res;
        begin
            if (mask == 5'd0)
            begin
                res = c;
            end
            else
            begin
                res = (c & ~{mask, 3'b000}) | {off & mask, 3'b000};
            end
            return res;
        end
    endfunction

    // row-major linear address, wraps over the whole memory
    function automatic logic [AW-1:0] linear(
        input logic [AW-1:0] row,
        input logic [AW-1:0] col
    );
        begin
            return (row << tfw_pkg::COL_W) + col;
        end
    endfunction

    // write address
    assign wr_addr = linear(AW'(mem_y), AW'(mem_x));

    // coordinates wrapped to 8 bits
    assign u_raw = mirror_x ? (u_start - column[7:0]) : (u_start + column[7:0]);
    assign v_raw = mirror_y ? (v_start - line[7:0]) : (v_start + line[7:0]);

    assign u_win = window_coord(u_raw, cfg.tex_window[4:0], cfg.tex_window[14:10]);
    assign v_win = window_coord(v_raw, cfg.tex_window[9:5], cfg.tex_window[19:15]);
    assign u_lo  = u_win[1:0];

    // word column inside the page depends on texel packing
    always_comb
    begin
        case (cfg.texture_format)
            tfw_pkg::FMT_4BIT: u_word = {2'b00, u_win[7:2]};
            tfw_pkg::FMT_8BIT: u_word = {1'b0, u_win[7:1]};
            default:           u_word = u_win;
        endcase
    end

    assign page_row  = {1'b0, cfg.page_y} + {2'b00, v_win};
    assign page_col  = {1'b0, cfg.page_x} + {3'b000, u_word};
    assign page_addr = linear(AW'(page_row), AW'(page_col));

    // palette index out of the packed word
    always_comb
    begin
        case (cfg.texture_format)
            tfw_pkg::FMT_4BIT: pal_idx = {4'd0, packed_word[{u_lo_held, 2'b00} +: 4]};
            default:           pal_idx = packed_word[{u_lo_held[0], 3'b000} +: 8];
        endcase
    end

    assign pal_col  = {1'b0, cfg.palette_x} + {3'b000, pal_idx};
    assign pal_addr = linear(AW'(cfg.palette_y), AW'(pal_col));

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the texture window texel fetch block. Items mix
// word writes and texel fetches; every fetch is predicted from a local copy
// of video memory and the register set, and results are checked in order.
// Video memory words are always written before any fetch reads them.
// ----------------------------------------------------------------------------
module tb_top;

    // both direct texel codes
    localparam logic [1:0] FMT_DIRECT     = 2'd2;
    localparam logic [1:0] FMT_DIRECT_ALT = 2'd3;

    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_PHASES = 8;
    localparam int RANDOM_ITEMS  = 336;
    localparam int TIMEOUT_TICKS = 1000000;

    typedef struct {
        logic        op;
        logic [9:0]  mem_x;
        logic [8:0]  mem_y;
        logic [15:0] write_data;
        logic [7:0]  u_start;
        logic [7:0]  v_start;
        logic [9:0]  column;
        logic [8:0]  line;
        logic        mirror_x;
        logic        mirror_y;
        logic        last_in;
    } tex_item_t;

    typedef struct packed {
        logic [15:0] texel;
        logic        last;
    } texel_exp_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [9:0]  mem_x;
    logic [8:0]  mem_y;
    logic [15:0] write_data;
    logic [7:0]  u_start;
    logic [7:0]  v_start;
    logic [9:0]  column;
    logic [8:0]  line;
    logic        mirror_x;
    logic        mirror_y;
    logic        last_in;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] texel;
    logic        last_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tfw_pkg::APB_ADDR_W-1:0] paddr;
    logic [tfw_pkg::APB_DATA_W-1:0] pwdata;
    logic [tfw_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    // local copy of video memory and registers
    logic [15:0]    vram_model [int unsigned];
    tfw_pkg::cfg_t  cfg_model;
    texel_exp_t     expected_texels [$];

    int          mismatch_count = 0;
    int          items_accepted = 0;
    int          tx_gap_max = 0;
    int          burst_left = 0;
    rx_mode_t    rx_mode = RX_ALWAYS;
    logic        hold_pending = 1'b0;

    texture_window_texel_fetch dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .mem_x      (mem_x),
        .mem_y      (mem_y),
        .write_data (write_data),
        .u_start    (u_start),
        .v_start    (v_start),
        .column     (column),
        .line       (line),
        .mirror_x   (mirror_x),
        .mirror_y   (mirror_y),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .texel      (texel),
        .last_out   (last_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // texel prediction
    // ------------------------------------------------------------------

    // linear word address, wrapping past the end of memory
    function automatic int unsigned vram_addr(int unsigned row, int unsigned col);
        return (row * tfw_pkg::MEM_WIDTH + col) %
               (tfw_pkg::MEM_WIDTH * tfw_pkg::MEM_HEIGHT);
    endfunction

    function automatic logic [7:0] apply_window(logic [7:0] c, logic [4:0] mask,
                                                logic [4:0] offs);
        if (mask == 5'd0)
            return c;
        return (c & ~{mask, 3'b000}) | {offs & mask, 3'b000};
    endfunction

    // u and v after mirror, 8-bit wrap and texture window
    function automatic void fetch_uv(input tex_item_t it, output logic [7:0] u,
                                     output logic [7:0] v);
        u = it.mirror_x ? it.u_start - it.column[7:0] : it.u_start + it.column[7:0];
        v = it.mirror_y ? it.v_start - it.line[7:0] : it.v_start + it.line[7:0];
        u = apply_window(u, cfg_model.tex_window[4:0], cfg_model.tex_window[14:10]);
        v = apply_window(v, cfg_model.tex_window[9:5], cfg_model.tex_window[19:15]);
    endfunction

    function automatic logic is_palette_mode();
        return cfg_model.texture_format == tfw_pkg::FMT_4BIT ||
               cfg_model.texture_format == tfw_pkg::FMT_8BIT;
    endfunction

    function automatic int unsigned page_word_addr(logic [7:0] u, logic [7:0] v);
        int unsigned row;
        int unsigned col;
        row = cfg_model.page_y + v;
        case (cfg_model.texture_format)
            tfw_pkg::FMT_4BIT: col = cfg_model.page_x + (u >> 2);
            tfw_pkg::FMT_8BIT: col = cfg_model.page_x + (u >> 1);
            default:           col = cfg_model.page_x + u;
        endcase
        return vram_addr(row, col);
    endfunction

    function automatic int unsigned palette_index(logic [15:0] word, logic [7:0] u);
        if (cfg_model.texture_format == tfw_pkg::FMT_4BIT)
            return (word >> {u[1:0], 2'b00}) & 16'h000F;
        return (word >> {u[0], 3'b000}) & 16'h00FF;
    endfunction

    function automatic int unsigned palette_addr(int unsigned idx);
        return vram_addr(cfg_model.palette_y, cfg_model.palette_x + idx);
    endfunction

    function automatic texel_exp_t predict_texel(tex_item_t it);
        logic [7:0]  u;
        logic [7:0]  v;
        logic [15:0] word;
        logic [15:0] pix;
        texel_exp_t  r;
        fetch_uv(it, u, v);
        word = vram_model[page_word_addr(u, v)];
        if (is_palette_mode())
            pix = vram_model[palette_addr(palette_index(word, u))];
        else
            pix = word;
        if (pix != 16'h0000)
            pix = pix | tfw_pkg::STP_BIT;
        r.texel = pix;
        r.last  = it.last_in;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic tex_item_t random_item();
        tex_item_t it;
        it.op         = tfw_pkg::OP_FETCH;
        it.mem_x      = 10'($urandom);
        it.mem_y      = 9'($urandom);
        it.write_data = 16'($urandom);
        it.u_start    = 8'($urandom);
        it.v_start    = 8'($urandom);
        it.column     = 10'($urandom);
        it.line       = 9'($urandom);
        it.mirror_x   = 1'($urandom);
        it.mirror_y   = 1'($urandom);
        it.last_in    = 1'($urandom);
        return it;
    endfunction

    function automatic tex_item_t mk_fetch(logic [7:0] us, logic [7:0] vs, logic [9:0] col,
                                           logic [8:0] row, logic mx, logic my, logic last);
        tex_item_t it;
        it          = random_item();
        it.u_start  = us;
        it.v_start  = vs;
        it.column   = col;
        it.line     = row;
        it.mirror_x = mx;
        it.mirror_y = my;
        it.last_in  = last;
        return it;
    endfunction

    // small offsets around a fixed start so that words and palette entries get reused
    function automatic tex_item_t local_fetch(logic [7:0] base_u, logic [7:0] base_v);
        tex_item_t it;
        it         = random_item();
        it.u_start = base_u;
        it.v_start = base_v;
        it.column  = 10'($urandom_range(0, 15));
        it.line    = 9'($urandom_range(0, 7));
        return it;
    endfunction

    // word data for first writes, transparent now and then
    function automatic logic [15:0] fill_data();
        return ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
    endfunction

    // sender bursts with random gaps
    task automatic pace_sender();
        int gap;
        if (tx_gap_max == 0)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 8);
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // offer one item, hold it until accepted, then update the model
    task automatic send_item(tex_item_t it);
        in_valid   <= 1'b1;
        op         <= it.op;
        mem_x      <= it.mem_x;
        mem_y      <= it.mem_y;
        write_data <= it.write_data;
        u_start    <= it.u_start;
        v_start    <= it.v_start;
        column     <= it.column;
        line       <= it.line;
        mirror_x   <= it.mirror_x;
        mirror_y   <= it.mirror_y;
        last_in    <= it.last_in;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_accepted++;
        if (it.op == tfw_pkg::OP_WRITE)
            vram_model[vram_addr(it.mem_y, it.mem_x)] = it.write_data;
        else
            expected_texels.push_back(predict_texel(it));
        pace_sender();
    endtask

    task automatic write_word(int unsigned addr, logic [15:0] data);
        tex_item_t it;
        it            = random_item();
        it.op         = tfw_pkg::OP_WRITE;
        it.mem_x      = 10'(addr % tfw_pkg::MEM_WIDTH);
        it.mem_y      = 9'(addr / tfw_pkg::MEM_WIDTH);
        it.write_data = data;
        send_item(it);
    endtask

    // write any word the fetch would read that holds nothing yet, then fetch
    task automatic fetch_texel(tex_item_t it);
        logic [7:0]  u;
        logic [7:0]  v;
        int unsigned a;
        it.op = tfw_pkg::OP_FETCH;
        fetch_uv(it, u, v);
        a = page_word_addr(u, v);
        if (!vram_model.exists(a))
            write_word(a, fill_data());
        if (is_palette_mode()) begin
            a = palette_addr(palette_index(vram_model[a], u));
            if (!vram_model.exists(a))
                write_word(a, fill_data());
        end
        send_item(it);
    endtask

    // stop offering items until every texel is back, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_texels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // register access
    // ------------------------------------------------------------------

    task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            tfw_pkg::REG_FORMAT:    cfg_model.texture_format = value[1:0];
            tfw_pkg::REG_PAGE_X:    cfg_model.page_x         = value[9:0];
            tfw_pkg::REG_PAGE_Y:    cfg_model.page_y         = value[8:0];
            tfw_pkg::REG_PALETTE_X: cfg_model.palette_x      = value[9:0];
            tfw_pkg::REG_PALETTE_Y: cfg_model.palette_y      = value[8:0];
            tfw_pkg::REG_WINDOW:    cfg_model.tex_window     = value[19:0];
            default:                ;
        endcase
        @(posedge clk);
    endtask

    task automatic cfg_read(logic [2:0] idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] cfg_reg_value(logic [2:0] idx);
        case (idx)
            tfw_pkg::REG_FORMAT:    return 32'(cfg_model.texture_format);
            tfw_pkg::REG_PAGE_X:    return 32'(cfg_model.page_x);
            tfw_pkg::REG_PAGE_Y:    return 32'(cfg_model.page_y);
            tfw_pkg::REG_PALETTE_X: return 32'(cfg_model.palette_x);
            tfw_pkg::REG_PALETTE_Y: return 32'(cfg_model.palette_y);
            tfw_pkg::REG_WINDOW:    return 32'(cfg_model.tex_window);
            default:                return 32'h0;
        endcase
    endfunction

    task automatic check_registers();
        int          i;
        logic [31:0] rd;
        for (i = tfw_pkg::REG_FORMAT; i <= tfw_pkg::REG_WINDOW; i++) begin
            cfg_read(3'(i), rd);
            if (rd !== cfg_reg_value(3'(i)))
                report_mismatch("register readback", rd, cfg_reg_value(3'(i)));
        end
    endtask

    task automatic apply_config(logic [1:0] fmt, logic [9:0] px, logic [8:0] py,
                                logic [9:0] lx, logic [8:0] ly, logic [19:0] win);
        cfg_write(tfw_pkg::REG_FORMAT, 32'(fmt));
        cfg_write(tfw_pkg::REG_PAGE_X, 32'(px));
        cfg_write(tfw_pkg::REG_PAGE_Y, 32'(py));
        cfg_write(tfw_pkg::REG_PALETTE_X, 32'(lx));
        cfg_write(tfw_pkg::REG_PALETTE_Y, 32'(ly));
        cfg_write(tfw_pkg::REG_WINDOW, 32'(win));
        check_registers();
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values, all-ones writes masked to width, back to zero
    task automatic test_register_access();
        int i;
        check_registers();
        for (i = tfw_pkg::REG_FORMAT; i <= tfw_pkg::REG_WINDOW; i++)
            cfg_write(3'(i), 32'hFFFF_FFFF);
        check_registers();
        for (i = tfw_pkg::REG_FORMAT; i <= tfw_pkg::REG_WINDOW; i++)
            cfg_write(3'(i), 32'h0);
        check_registers();
    endtask

    task automatic test_directed_fetch();
        tx_gap_max = 2;
        rx_mode    = RX_PATTERN;

        // 4-bit palette at the end of the last row, high indexes wrap to the start
        apply_config(tfw_pkg::FMT_4BIT, 10'd0, 9'd0, 10'd1020, 9'd511, 20'h0);
        write_word(vram_addr(0, 0), 16'hF0A5);
        write_word(vram_addr(511, 1020), 16'h0000);
        write_word(vram_addr(0, 11), 16'h7FFF);
        fetch_texel(mk_fetch(8'd3, 8'd0, 10'd0, 9'd0, 1'b0, 1'b0, 1'b1));
        fetch_texel(mk_fetch(8'd2, 8'd0, 10'd0, 9'd0, 1'b0, 1'b0, 1'b0));
        // largest offsets, first mirrored and then not
        fetch_texel(mk_fetch(8'd0, 8'd0, 10'd1023, 9'd511, 1'b1, 1'b1, 1'b0));
        fetch_texel(mk_fetch(8'd255, 8'd255, 10'd1023, 9'd511, 1'b0, 1'b0, 1'b1));
        settle();

        // 8-bit palette, page at the far corner, window fully set
        apply_config(tfw_pkg::FMT_8BIT, 10'd1023, 9'd511, 10'd0, 9'd0, 20'hFFFFF);
        fetch_texel(mk_fetch(8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 1'b0, 1'b0));
        fetch_texel(mk_fetch(8'h5A, 8'hC3, 10'd17, 9'd300, 1'b1, 1'b0, 1'b1));
        settle();

        // direct texels at the last word; one step right runs off the end of memory
        apply_config(FMT_DIRECT, 10'd1023, 9'd511, 10'd0, 9'd0, 20'h0);
        write_word(vram_addr(511, 1023), 16'hFFFF);
        fetch_texel(mk_fetch(8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 1'b0, 1'b1));
        fetch_texel(mk_fetch(8'd1, 8'd0, 10'd0, 9'd0, 1'b0, 1'b0, 1'b0));
        fetch_texel(mk_fetch(8'd0, 8'd1, 10'd0, 9'd0, 1'b0, 1'b0, 1'b0));
        settle();

        // second direct code, x mask only with a y offset that must be ignored
        apply_config(FMT_DIRECT_ALT, 10'd512, 9'd256, 10'd0, 9'd0,
                     {5'h1F, 5'h00, 5'h00, 5'h1F});
        write_word(vram_addr(256 + 9, 512 + 5), 16'h0000);
        fetch_texel(mk_fetch(8'd13, 8'd9, 10'd0, 9'd0, 1'b0, 1'b0, 1'b1));
        fetch_texel(mk_fetch(8'd200, 8'd40, 10'd300, 9'd100, 1'b1, 1'b1, 1'b0));
        settle();
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          start;
        int          pick;
        int unsigned addr;
        logic [7:0]  base_u;
        logic [7:0]  base_v;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_config(tfw_pkg::FMT_4BIT, 10'd1023, 9'd511, 10'd1023, 9'd511,
                                20'hFFFFF);
                1: apply_config(tfw_pkg::FMT_8BIT, 10'd0, 9'd0, 10'd0, 9'd0, 20'h0);
                default: apply_config(2'(phase % 4), 10'($urandom), 9'($urandom),
                                      10'($urandom), 9'($urandom),
                                      ($urandom_range(0, 2) == 0) ? 20'h0 : 20'($urandom));
            endcase
            tx_gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 6);
            rx_mode    = rx_mode_t'(phase % 3);
            base_u     = 8'($urandom);
            base_v     = 8'($urandom);
            start      = items_accepted;
            while (items_accepted - start < RANDOM_ITEMS / RANDOM_PHASES) begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    // stray writes, anywhere or over the page words in use
                    if (pick == 0)
                        addr = $urandom_range(0,
                                   tfw_pkg::MEM_WIDTH * tfw_pkg::MEM_HEIGHT - 1);
                    else
                        addr = vram_addr(cfg_model.page_y + $urandom_range(0, 7),
                                         cfg_model.page_x + $urandom_range(0, 15));
                    write_word(addr, 16'($urandom));
                end
                else if (pick < 7)
                    fetch_texel(local_fetch(base_u, base_v));
                else
                    fetch_texel(random_item());
            end
            settle();
        end
    endtask

    // long receiver hold while fetches keep coming, then a drain and more traffic
    task automatic test_output_backpressure();
        logic [7:0] base_u;
        logic [7:0] base_v;
        apply_config(tfw_pkg::FMT_8BIT, 10'($urandom), 9'($urandom), 10'($urandom),
                     9'($urandom), 20'h0);
        base_u       = 8'($urandom);
        base_v       = 8'($urandom);
        tx_gap_max   = 0;
        rx_mode      = RX_ALWAYS;
        hold_pending = 1'b1;
        repeat (24) fetch_texel(local_fetch(base_u, base_v));
        settle();
        tx_gap_max = 3;
        rx_mode    = RX_RANDOM;
        repeat (12) fetch_texel(local_fetch(base_u, base_v));
        settle();
    endtask

    // ------------------------------------------------------------------
    // receiver: ready pattern per mode, plus the long hold on request
    // ------------------------------------------------------------------
    initial begin
        int rx_tick;
        rx_tick = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:  out_ready <= 1'b1;
                RX_RANDOM:  out_ready <= ($urandom_range(0, 99) < 60);
                default:    out_ready <= (rx_tick % 9) < 5;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result check against the oldest expected texel
    // ------------------------------------------------------------------
    always @(posedge clk) begin : texel_check
        texel_exp_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_texels.size() == 0)
                report_mismatch("texel with no fetch pending", 32'(texel), 32'h0);
            else begin
                want = expected_texels.pop_front();
                if (texel !== want.texel)
                    report_mismatch("texel", 32'(texel), 32'(want.texel));
                if (last_out !== want.last)
                    report_mismatch("last_out", 32'(last_out), 32'(want.last));
            end
        end
    end

    // run limit
    initial begin
        #(TIMEOUT_TICKS);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        op         <= tfw_pkg::OP_WRITE;
        mem_x      <= '0;
        mem_y      <= '0;
        write_data <= '0;
        u_start    <= '0;
        v_start    <= '0;
        column     <= '0;
        line       <= '0;
        mirror_x   <= 1'b0;
        mirror_y   <= 1'b0;
        last_in    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cfg_model  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_directed_fetch();
        test_random_traffic();
        test_output_backpressure();

        settle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tfw_pkg.sv
rtl/tfw_vram.sv
rtl/tfw_regs.sv
rtl/tfw_addr.sv
rtl/texture_window_texel_fetch.sv
bench/tb_top.sv
